// File: src/lkv_pkg.sv
// ============================================================================
// lkv_pkg: shared types and constants for the LRU key-value cache
// Field widths, stream bit positions, command codes and the
// controller/datapath command and status structs.
// ============================================================================
package lkv_pkg;

    localparam int FIELD_W  = 64;
    localparam int CAP_W    = 5;
    localparam int TDATA_W  = 2 * FIELD_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_USER_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam int USER_HIT   = 0;
    localparam int USER_EVICT = 1;

    typedef struct packed {
        logic load_in;
        logic capture;
        logic update;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic modify;
    } t_dp_stat;

endpackage

// File: src/lkv_ram.sv
// ============================================================================
// lkv_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lkv_ctrl.sv
// ============================================================================
// lkv_ctrl: request sequencer
// Steps one request through accept, match, update and result, and owns
// the result valid flag.
// ============================================================================
module lkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lkv_pkg::t_dp_stat i_stat,
    output lkv_pkg::t_dp_cmd  o_cmd
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.capture = 1'b1;
                n_state       = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = i_stat.modify;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: src/lkv_datapath.sv
// ============================================================================
// lkv_datapath: tag array, recency ranks, value store and result register
// Parallel key compare, victim and free-slot search, rank aging and
// the capacity register.
// ============================================================================
module lkv_datapath #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkv_pkg::t_dp_cmd            i_cmd,
    output lkv_pkg::t_dp_stat           o_stat,
    input  logic                        i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        i_command,
    input  logic [lkv_pkg::FIELD_W-1:0] i_lookup_key,
    input  logic [lkv_pkg::FIELD_W-1:0] i_write_value,
    output logic                        o_hit,
    output logic [lkv_pkg::FIELD_W-1:0] o_read_value,
    output logic                        o_evicted,
    output logic [lkv_pkg::FIELD_W-1:0] o_evicted_key
);
    import lkv_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]    r_valid;
    logic [KEY_BITS-1:0]   r_key [ENTRIES];
    logic [IDX_W-1:0]      r_rank [ENTRIES];
    logic [CNT_W-1:0]      r_count;
    logic [CAP_W-1:0]      r_cap;

    logic                  r_is_put;
    logic [KEY_BITS-1:0]   r_in_key;
    logic [VALUE_BITS-1:0] r_in_val;
    logic                  r_hit;
    logic                  r_evict;
    logic [IDX_W-1:0]      r_slot;
    logic [IDX_W-1:0]      r_old_rank;
    logic [KEY_BITS-1:0]   r_ev_key;

    logic                  r_o_hit;
    logic                  r_o_evicted;
    logic [VALUE_BITS-1:0] r_o_read;
    logic [KEY_BITS-1:0]   r_o_ev_key;

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    oldest;
    logic [IDX_W-1:0]      found_idx;
    logic [IDX_W-1:0]      victim_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [CNT_W-1:0]      eff_cap;
    logic [CNT_W-1:0]      count_m1;
    logic                  any_hit;
    logic                  has_room;
    logic                  need_evict;
    logic                  get_hit;
    logic                  ram_we;
    logic                  ram_re;
    logic [VALUE_BITS-1:0] ram_rdata;

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(r_cap) > ENTRIES) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
    end

    assign count_m1 = r_count - CNT_W'(1);

    always_comb begin
        match      = '0;
        oldest     = '0;
        found_idx  = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_key[i] == r_in_key);
            oldest[i] = r_valid[i] && (CNT_W'(r_rank[i]) == count_m1);
            if (match[i]) begin
                found_idx = found_idx | IDX_W'(i);
            end
            if (oldest[i]) begin
                victim_idx = victim_idx | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit    = |match;
    assign has_room   = (r_count < eff_cap);
    assign need_evict = r_is_put && !any_hit && !has_room;
    assign get_hit    = r_hit && !r_is_put;

    assign o_stat.modify = r_hit || r_is_put;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we && (r_count == '0)) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.update) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (!r_hit || (r_rank[i] < r_old_rank))) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                r_valid[r_slot] <= 1'b1;
                if (!r_hit && !r_evict) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_is_put <= (i_command == CMD_PUT);
            r_in_key <= i_lookup_key[KEY_BITS-1:0];
            r_in_val <= i_write_value[VALUE_BITS-1:0];
        end
        if (i_cmd.capture) begin
            r_hit      <= any_hit;
            r_evict    <= need_evict;
            r_old_rank <= r_rank[found_idx];
            r_ev_key   <= need_evict ? r_key[victim_idx] : '0;
            if (any_hit) begin
                r_slot <= found_idx;
            end else if (has_room) begin
                r_slot <= free_idx;
            end else begin
                r_slot <= victim_idx;
            end
        end
        if (i_cmd.update && !r_hit) begin
            r_key[r_slot] <= r_in_key;
        end
        if (i_cmd.load_out) begin
            r_o_hit     <= r_hit;
            r_o_evicted <= r_evict;
            r_o_read    <= get_hit ? ram_rdata : '0;
            r_o_ev_key  <= r_ev_key;
        end
    end

    assign ram_we = i_cmd.update && r_is_put;
    assign ram_re = i_cmd.update && get_hit;

    lkv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_in_val),
        .i_re    (ram_re),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    assign o_hit         = r_o_hit;
    assign o_evicted     = r_o_evicted;
    assign o_read_value  = FIELD_W'(r_o_read);
    assign o_evicted_key = FIELD_W'(r_o_ev_key);

endmodule

// File: src/lru_key_value_cache.sv
// The sequencer walks match, update and result for one request at a time
// through the value RAM port, and takes a new input only once the result
// has been registered on the output.
// A result waiting on the output does not block the next input transfer.
// Reset (synchronous, active low) clears all valid bits, ranks and the entry
// count and sets capacity to 16; no clearing pass, ready right after reset.
// ============================================================================
// lru_key_value_cache: fully associative key-value store with LRU eviction
// Get and put requests on a stream input, one result per request on a
// stream output, and a capacity register taken while the store is empty.
// ============================================================================
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [63:0] lookup_key, [127:64] write_value
    input  logic [lkv_pkg::TDATA_W-1:0]    i_s_axis_tdata,
    // [0] command
    input  logic [lkv_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [63:0] read_value, [127:64] evicted_key
    output logic [lkv_pkg::TDATA_W-1:0]    o_m_axis_tdata,
    // [0] hit, [1] evicted
    output logic [lkv_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import lkv_pkg::*;

    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;
    logic               hit;
    logic               evicted;
    logic [FIELD_W-1:0] read_value;
    logic [FIELD_W-1:0] evicted_key;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    lkv_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_s_axis_tuser[0]),
        .i_lookup_key  (i_s_axis_tdata[FIELD_W-1:0]),
        .i_write_value (i_s_axis_tdata[TDATA_W-1:FIELD_W]),
        .o_hit         (hit),
        .o_read_value  (read_value),
        .o_evicted     (evicted),
        .o_evicted_key (evicted_key)
    );

    assign o_m_axis_tdata = {evicted_key, read_value};
    assign o_m_axis_tuser = {evicted, hit};

endmodule

// File: src/lkv_checker.sv
// ============================================================================
// lkv_checker: port-level checks for the LRU key-value cache
// Result consistency, output hold under stall and one request in flight.
// ============================================================================
module lkv_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [lkv_pkg::TDATA_W-1:0]    o_m_axis_tdata,
    input logic [lkv_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import lkv_pkg::*;

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[USER_EVICT]) |-> !o_m_axis_tuser[USER_HIT])
        else $error("eviction reported on a hit");

    a_miss_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[USER_HIT]) |->
        (o_m_axis_tdata[FIELD_W-1:0] == '0))
        else $error("nonzero read value on a miss");

    a_no_evict_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[USER_EVICT]) |->
        (o_m_axis_tdata[TDATA_W-1:FIELD_W] == '0))
        else $error("nonzero evicted key without eviction");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a request is in flight");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
